[src/tcg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types, the 5x7 font and the style palette for the text cell row
// generator.
// ----------------------------------------------------------------------------
package tcg_pkg;

	// Cell geometry. Columns at or beyond CELL_WIDTH and rows at or beyond
	// CELL_HEIGHT are clipped.
	localparam int CELL_WIDTH  = 8;
	localparam int CELL_HEIGHT = 16;

	localparam int MASK_W      = 8;
	localparam int COLOR_W     = 16;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int FONT_DEPTH  = 69;
	localparam int FONT_IDX_W  = $clog2(FONT_DEPTH);

	localparam logic [FONT_IDX_W-1:0] QMARK_INDEX = FONT_IDX_W'(31);

	// Style codes
	localparam logic [2:0] STYLE_PROMPT = 3'd0;
	localparam logic [2:0] STYLE_INPUT  = 3'd1;
	localparam logic [2:0] STYLE_OUTPUT = 3'd2;
	localparam logic [2:0] STYLE_ERROR  = 3'd3;
	localparam logic [2:0] STYLE_STATUS = 3'd4;
	localparam logic [2:0] STYLE_SYSTEM = 3'd5;

	// RGB565 palette
	localparam logic [COLOR_W-1:0] COLOR_BLACK   = 16'h0000;
	localparam logic [COLOR_W-1:0] COLOR_WHITE   = 16'hFFFF;
	localparam logic [COLOR_W-1:0] COLOR_CYAN    = 16'h7EFF;
	localparam logic [COLOR_W-1:0] COLOR_NAVY    = 16'h0883;
	localparam logic [COLOR_W-1:0] COLOR_GREY    = 16'hD69A;
	localparam logic [COLOR_W-1:0] COLOR_RED     = 16'hFAEB;
	localparam logic [COLOR_W-1:0] COLOR_AMBER   = 16'hFE8B;
	localparam logic [COLOR_W-1:0] COLOR_CHARCOAL = 16'h10A2;
	localparam logic [COLOR_W-1:0] COLOR_SAGE    = 16'h8DB2;

	typedef struct packed {
		logic [7:0] char_code;
		logic [2:0] style;
		logic       cursor_here;
		logic [3:0] pixel_row;
	} cell_word_t;

	typedef struct packed {
		logic [MASK_W-1:0]  ink_mask;
		logic [COLOR_W-1:0] ink_color;
		logic [COLOR_W-1:0] paper_color;
	} row_word_t;

	typedef logic [GLYPH_COLS*GLYPH_ROWS-1:0] glyph_t;

	// Glyphs for 0x20..0x60, then 0x7B..0x7E. Top row in the high bits,
	// bit 4 of each row is the leftmost column.
	localparam glyph_t FONT [FONT_DEPTH] = '{
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04},
		{5'h0a,5'h0a,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h0a,5'h1f,5'h0a,5'h0a,5'h1f,5'h0a,5'h00},
		{5'h04,5'h0f,5'h14,5'h0e,5'h05,5'h1e,5'h04}, {5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03},
		{5'h0c,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0d}, {5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00},
		{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}, {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
		{5'h00,5'h15,5'h0e,5'h1f,5'h0e,5'h15,5'h00}, {5'h00,5'h04,5'h04,5'h1f,5'h04,5'h04,5'h00},
		{5'h00,5'h00,5'h00,5'h00,5'h04,5'h04,5'h08}, {5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00},
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c}, {5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00},
		{5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e}, {5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e},
		{5'h0e,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1f}, {5'h1f,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0e},
		{5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02}, {5'h1f,5'h10,5'h1e,5'h01,5'h01,5'h11,5'h0e},
		{5'h06,5'h08,5'h10,5'h1e,5'h11,5'h11,5'h0e}, {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		{5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e}, {5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h02,5'h0c},
		{5'h00,5'h0c,5'h0c,5'h00,5'h0c,5'h0c,5'h00}, {5'h00,5'h0c,5'h0c,5'h00,5'h04,5'h04,5'h08},
		{5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02}, {5'h00,5'h00,5'h1f,5'h00,5'h1f,5'h00,5'h00},
		{5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08}, {5'h0e,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
		{5'h0e,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0e},
		{5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11}, {5'h1e,5'h11,5'h11,5'h1e,5'h11,5'h11,5'h1e},
		{5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e}, {5'h1e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1e},
		{5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f}, {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10},
		{5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0f}, {5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11},
		{5'h0e,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0e}, {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0c},
		{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f},
		{5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11}, {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
		{5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e}, {5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10},
		{5'h0e,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0d}, {5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11},
		{5'h0f,5'h10,5'h10,5'h0e,5'h01,5'h01,5'h1e}, {5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e}, {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0a,5'h04},
		{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a}, {5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11},
		{5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04}, {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1f},
		{5'h0e,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0e}, {5'h10,5'h08,5'h04,5'h02,5'h01,5'h00,5'h00},
		{5'h0e,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0e}, {5'h04,5'h0a,5'h11,5'h00,5'h00,5'h00,5'h00},
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1f}, {5'h08,5'h04,5'h02,5'h00,5'h00,5'h00,5'h00},
		{5'h02,5'h04,5'h04,5'h18,5'h04,5'h04,5'h02}, {5'h04,5'h04,5'h04,5'h00,5'h04,5'h04,5'h04},
		{5'h08,5'h04,5'h04,5'h03,5'h04,5'h04,5'h08}, {5'h00,5'h00,5'h08,5'h15,5'h02,5'h00,5'h00}
	};

	// Fold lowercase, map printable codes to a font entry, others to '?'.
	function automatic logic [FONT_IDX_W-1:0] font_index(input logic [7:0] code);
		logic [7:0] c;
		logic [FONT_IDX_W-1:0] idx;
		c = code;
		if (c inside {[8'h61:8'h7a]}) begin
			c = c - 8'h20;
		end
		if (c inside {[8'h20:8'h60]}) begin
			idx = FONT_IDX_W'(c - 8'h20);
		end else if (c inside {[8'h7b:8'h7e]}) begin
			idx = FONT_IDX_W'(c - 8'h7b) + FONT_IDX_W'(65);
		end else begin
			idx = QMARK_INDEX;
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

[src/tcg_glyph_row.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcg_glyph_row
// Combinational row builder: font lookup, 2x scaling with offset and clipping,
// and the style palette with cursor swap.
// ----------------------------------------------------------------------------
module tcg_glyph_row #(
	parameter int CELL_WIDTH  = tcg_pkg::CELL_WIDTH,
	parameter int CELL_HEIGHT = tcg_pkg::CELL_HEIGHT
) (
	input  wire tcg_pkg::cell_word_t cell_data,
	output tcg_pkg::row_word_t       row
);

	logic [tcg_pkg::FONT_IDX_W-1:0] glyph_idx;
	tcg_pkg::glyph_t                glyph;
	logic [2:0]                     glyph_line;
	logic [tcg_pkg::GLYPH_COLS-1:0] line_bits;
	logic                           row_visible;
	logic [tcg_pkg::MASK_W-1:0]     mask;
	logic [tcg_pkg::COLOR_W-1:0]    fg;
	logic [tcg_pkg::COLOR_W-1:0]    bg;

	assign glyph_idx  = tcg_pkg::font_index(cell_data.char_code);
	assign glyph      = tcg_pkg::FONT[glyph_idx];
	// One pixel down, two pixels per glyph line
	assign glyph_line = 3'((cell_data.pixel_row - 4'd1) >> 1);
	assign row_visible = (cell_data.pixel_row >= 4'd1) && (cell_data.pixel_row <= 4'd14) &&
		(32'(cell_data.pixel_row) < 32'(CELL_HEIGHT));

	always_comb begin
		line_bits = '0;
		if (row_visible) begin
			line_bits = glyph[tcg_pkg::GLYPH_COLS * (6 - int'(glyph_line)) +: tcg_pkg::GLYPH_COLS];
		end
	end

	// Column x shows glyph column (x-1)/2; column 0 is the left margin.
	always_comb begin
		mask = '0;
		for (int x = 1; x < tcg_pkg::MASK_W; x++) begin
			if (x < CELL_WIDTH && ((x - 1) >> 1) < tcg_pkg::GLYPH_COLS) begin
				mask[x] = line_bits[tcg_pkg::GLYPH_COLS - 1 - ((x - 1) >> 1)];
			end
		end
	end

	always_comb begin
		case (cell_data.style)
			tcg_pkg::STYLE_PROMPT: begin
				fg = tcg_pkg::COLOR_CYAN;
				bg = tcg_pkg::COLOR_BLACK;
			end
			tcg_pkg::STYLE_INPUT: begin
				fg = tcg_pkg::COLOR_WHITE;
				bg = tcg_pkg::COLOR_NAVY;
			end
			tcg_pkg::STYLE_OUTPUT: begin
				fg = tcg_pkg::COLOR_GREY;
				bg = tcg_pkg::COLOR_BLACK;
			end
			tcg_pkg::STYLE_ERROR: begin
				fg = tcg_pkg::COLOR_RED;
				bg = tcg_pkg::COLOR_BLACK;
			end
			tcg_pkg::STYLE_STATUS: begin
				fg = tcg_pkg::COLOR_AMBER;
				bg = tcg_pkg::COLOR_CHARCOAL;
			end
			default: begin
				// system, and the unused codes drawn as system
				fg = tcg_pkg::COLOR_SAGE;
				bg = tcg_pkg::COLOR_BLACK;
			end
		endcase
	end

	assign row.ink_mask    = mask;
	assign row.ink_color   = cell_data.cursor_here ? bg : fg;
	assign row.paper_color = cell_data.cursor_here ? fg : bg;

endmodule
`default_nettype wire

[src/text_cell_glyph_row_generator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_glyph_row_generator_top
// One pixel row of one text cell: ink mask plus ink and paper colours.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Word
//  --------+-----------+-------------------------+---------------------------
//  cell    | in        | cell_valid / cell_stall | char, style, cursor, row
//  row     | out       | row_valid / row_stall   | ink mask, ink/paper color
//
//  A row word shows on the outputs after its cell word has passed the input
//  and result registers; one word enters every cycle while row_stall is low.
//  Font ROM, scaling and palette logic sit between the input register and
//  the result register; no state is carried between words.
//  arst_n clears both valid flags; payload registers are not reset.
//  row_stall holds the result register; cell_stall rises only when both are full.
//
// ----------------------------------------------------------------------------
module text_cell_glyph_row_generator_top #(
	parameter int CELL_WIDTH  = tcg_pkg::CELL_WIDTH,
	parameter int CELL_HEIGHT = tcg_pkg::CELL_HEIGHT
) (
	input  wire                        clk,
	input  wire                        arst_n,

	input  wire                        cell_valid,
	output logic                       cell_stall,
	input  wire tcg_pkg::cell_word_t   cell_data,

	output logic                       row_valid,
	input  wire                        row_stall,
	output tcg_pkg::row_word_t         row
);

	logic                 valid_s1;
	tcg_pkg::cell_word_t  word_s1;
	logic                 valid_s2;
	tcg_pkg::row_word_t   word_s2;
	tcg_pkg::row_word_t   row_next;
	logic                 advance_s2;
	logic                 advance_s1;

	// Result stage moves when empty or when its word is taken.
	assign advance_s2 = !valid_s2 || !row_stall;
	// Input stage moves when empty or when it can hand off downstream.
	assign advance_s1 = !valid_s1 || advance_s2;

	assign cell_stall = !advance_s1;

	// Input register: hold while stalled, load a new word otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && cell_valid) begin
			word_s1 <= cell_data;
		end
	end

	// Font lookup, scaling and palette, all between the two registers.
	tcg_glyph_row #(
		.CELL_WIDTH  (CELL_WIDTH),
		.CELL_HEIGHT (CELL_HEIGHT)
	) u_glyph_row (
		.cell_data (word_s1),
		.row       (row_next)
	);

	// Result register: drop the valid once taken, advance when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			word_s2 <= row_next;
		end
	end

	assign row_valid = valid_s2;
	assign row       = word_s2;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph row generator testbench
// Feeds cell words (character, style, cursor, pixel row) into the text cell
// row generator with bursty valid and patterned row stalls, including one
// long hold-off that backs the pipeline up. Each row word is checked field by
// field against an independent prediction of the font lookup, the 2x
// scaling with its one-pixel offset, the clipping and the style palette.
// ----------------------------------------------------------------------------

package glyph_row_check_pkg;

	localparam int GLYPH_QMARK = 31;
	localparam int MAX_REPORTS = 40;

	// One glyph per entry, top row in the high byte; bit 4 of each row byte
	// is the leftmost glyph column. Codes 0x20..0x60, then 0x7B..0x7E.
	localparam bit [55:0] GLYPHS [69] = '{
		56'h00000000000000, 56'h04040404040004, 56'h0a0a0000000000, 56'h0a1f0a0a1f0a00,
		56'h040f140e051e04, 56'h18190204081303, 56'h0c12140815120d, 56'h04040800000000,
		56'h02040808080402, 56'h08040202020408, 56'h00150e1f0e1500, 56'h0004041f040400,
		56'h00000000040408, 56'h0000001f000000, 56'h00000000000c0c, 56'h01020408100000,
		56'h0e11131519110e, 56'h040c040404040e, 56'h0e11010204081f, 56'h1f02040201110e,
		56'h02060a121f0202, 56'h1f101e0101110e, 56'h0608101e11110e, 56'h1f010204080808,
		56'h0e11110e11110e, 56'h0e11110f01020c, 56'h000c0c000c0c00, 56'h000c0c00040408,
		56'h02040810080402, 56'h00001f001f0000, 56'h08040201020408, 56'h0e110102040004,
		56'h0e11171517100e, 56'h0e11111f111111, 56'h1e11111e11111e, 56'h0e11101010110e,
		56'h1e11111111111e, 56'h1f10101e10101f, 56'h1f10101e101010, 56'h0e11101711110f,
		56'h1111111f111111, 56'h0e04040404040e, 56'h0702020212120c, 56'h11121418141211,
		56'h1010101010101f, 56'h111b1515111111, 56'h11191513111111, 56'h0e11111111110e,
		56'h1e11111e101010, 56'h0e11111115120d, 56'h1e11111e141211, 56'h0f10100e01011e,
		56'h1f040404040404, 56'h1111111111110e, 56'h11111111110a04, 56'h1111111515150a,
		56'h11110a040a1111, 56'h11110a04040404, 56'h1f01020408101f, 56'h0e08080808080e,
		56'h10080402010000, 56'h0e02020202020e, 56'h040a1100000000, 56'h0000000000001f,
		56'h08040200000000, 56'h02040418040402, 56'h04040400040404, 56'h08040403040408,
		56'h00000815020000
	};

	function automatic int glyph_slot(bit [7:0] code);
		bit [7:0] c;
		c = code;
		if (c >= 8'h61 && c <= 8'h7a) begin
			c = c - 8'h20;
		end
		if (c >= 8'h20 && c <= 8'h60) begin
			return int'(c) - 'h20;
		end else if (c >= 8'h7b && c <= 8'h7e) begin
			return 65 + int'(c) - 'h7b;
		end
		return GLYPH_QMARK;
	endfunction

	function automatic bit [15:0] rgb565(bit [7:0] r, bit [7:0] g, bit [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic tcg_pkg::row_word_t predict_row(tcg_pkg::cell_word_t w);
		tcg_pkg::row_word_t r;
		bit [55:0] glyph;
		bit [7:0] bits;
		bit [15:0] fg, bg;
		int rr, x, gx;
		r = '0;
		glyph = GLYPHS[glyph_slot(w.char_code)];
		// Rows 1..14 carry the doubled glyph; row 0 and row 15 stay blank.
		if (w.pixel_row >= 1 && w.pixel_row <= 14 &&
			int'(w.pixel_row) < tcg_pkg::CELL_HEIGHT) begin
			rr = (int'(w.pixel_row) - 1) / 2;
			bits = glyph[55 - 8 * rr -: 8];
			for (x = 1; x < tcg_pkg::CELL_WIDTH && x < tcg_pkg::MASK_W; x++) begin
				gx = (x - 1) / 2;
				if (gx < tcg_pkg::GLYPH_COLS && bits[4 - gx]) begin
					r.ink_mask[x] = 1'b1;
				end
			end
		end
		case (w.style)
			tcg_pkg::STYLE_PROMPT: begin
				fg = rgb565(120, 220, 255);
				bg = rgb565(0, 0, 0);
			end
			tcg_pkg::STYLE_INPUT: begin
				fg = 16'hffff;
				bg = rgb565(10, 16, 24);
			end
			tcg_pkg::STYLE_OUTPUT: begin
				fg = rgb565(210, 210, 210);
				bg = rgb565(0, 0, 0);
			end
			tcg_pkg::STYLE_ERROR: begin
				fg = rgb565(255, 95, 95);
				bg = rgb565(0, 0, 0);
			end
			tcg_pkg::STYLE_STATUS: begin
				fg = rgb565(255, 210, 90);
				bg = rgb565(20, 20, 20);
			end
			default: begin
				fg = rgb565(140, 180, 150);
				bg = rgb565(0, 0, 0);
			end
		endcase
		r.ink_color   = w.cursor_here ? bg : fg;
		r.paper_color = w.cursor_here ? fg : bg;
		return r;
	endfunction

	class row_scoreboard;
		tcg_pkg::row_word_t expected_rows[$];
		int n_fail = 0;
		int n_rows = 0;

		task report(string msg);
			if (n_fail < MAX_REPORTS) begin
				$display("row word %0d: %s", n_rows, msg);
			end
			n_fail++;
		endtask

		function void note_cell(tcg_pkg::cell_word_t w);
			expected_rows.push_back(predict_row(w));
		endfunction

		task check_row(tcg_pkg::row_word_t got);
			tcg_pkg::row_word_t want;
			if (expected_rows.size() == 0) begin
				report("row word with no cell word outstanding");
			end else begin
				want = expected_rows.pop_front();
				if (got.ink_mask !== want.ink_mask) begin
					report($sformatf("ink_mask got %h want %h", got.ink_mask, want.ink_mask));
				end
				if (got.ink_color !== want.ink_color) begin
					report($sformatf("ink_color got %h want %h", got.ink_color,
						want.ink_color));
				end
				if (got.paper_color !== want.paper_color) begin
					report($sformatf("paper_color got %h want %h", got.paper_color,
						want.paper_color));
				end
			end
			n_rows++;
		endtask

		function int pending();
			return expected_rows.size();
		endfunction
	endclass

endpackage

module tb;

	localparam int RANDOM_CELLS = 700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;

	logic                clk;
	logic                arst_n;
	logic                cell_valid;
	logic                cell_stall;
	tcg_pkg::cell_word_t cell_data;
	logic                row_valid;
	logic                row_stall;
	tcg_pkg::row_word_t  row;

	glyph_row_check_pkg::row_scoreboard sb = new();
	int n_sent = 0;
	int cycles = 0;

	text_cell_glyph_row_generator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_data  (cell_data),
		.row_valid  (row_valid),
		.row_stall  (row_stall),
		.row        (row)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the pipeline wedges.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one cell word and hold it until the edge that takes it.
	// cell_stall is read right after the edge, so it is the value the block
	// saw at that edge.
	task automatic send_cell(tcg_pkg::cell_word_t w);
		cell_data  <= w;
		cell_valid <= 1'b1;
		@(posedge clk);
		while (cell_stall !== 1'b0) begin
			@(posedge clk);
		end
		sb.note_cell(w);
		n_sent++;
	endtask

	// Drop valid for a gap; the payload stays as it was.
	task automatic idle_cells(int n);
		cell_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Directed words: control codes, DEL, high bytes, both ends of the
	// lowercase range, the brace/tilde group, blank rows at top and bottom,
	// every style (the two spare codes fall back to system) with and
	// without the cursor.
	function automatic tcg_pkg::cell_word_t directed_cell(int i);
		bit [7:0] codes [12];
		bit [3:0] rows [6];
		tcg_pkg::cell_word_t w;
		codes = '{8'h00, 8'hff, 8'h20, 8'h7f, 8'h41, 8'h61, 8'h7a, 8'h7b, 8'h7e,
			8'h60, 8'h3f, 8'h80};
		rows = '{4'd0, 4'd1, 4'd14, 4'd15, 4'd7, 4'd8};
		w.char_code   = codes[i % 12];
		w.style       = 3'(i % 8);
		w.cursor_here = 1'((i >> 3) & 1);
		w.pixel_row   = rows[i % 6];
		return w;
	endfunction

	// Mostly printable glyphs, a good share of lowercase, and the odd byte
	// from anywhere so the question mark path stays busy.
	function automatic tcg_pkg::cell_word_t random_cell();
		tcg_pkg::cell_word_t w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: w.char_code = 8'($urandom_range('h20, 'h7e));
			6, 7:             w.char_code = 8'($urandom_range('h61, 'h7a));
			default:          w.char_code = 8'($urandom_range(0, 255));
		endcase
		w.style       = 3'($urandom_range(0, 7));
		w.cursor_here = 1'($urandom_range(0, 1));
		w.pixel_row   = 4'($urandom_range(0, 15));
		return w;
	endfunction

	// Stimulus: reset, directed words, then random bursts with random gaps.
	initial begin
		int i;
		int k;
		int burst;
		arst_n     <= 1'b0;
		cell_valid <= 1'b0;
		cell_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 24; i++) begin
			send_cell(directed_cell(i));
			if (i % 5 == 4) begin
				idle_cells(1);
			end
		end

		k = 0;
		while (k < RANDOM_CELLS) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && k < RANDOM_CELLS) begin
				send_cell(random_cell());
				burst--;
				k++;
			end
			// Some bursts run straight into the next one.
			if ($urandom_range(0, 3) != 0) begin
				idle_cells($urandom_range(1, 8));
			end
		end
		cell_valid <= 1'b0;

		// Drain, then give the two-stage pipe time to show any stray word.
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		if (sb.n_fail == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Row side stalls: segments of no stall, light stall, heavy stall and a
	// strict alternation, plus one long hold-off once traffic is flowing so
	// both stages fill and cell_stall has to rise.
	initial begin
		int seg;
		int mode;
		int j;
		bit held;
		held = 1'b0;
		row_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && n_sent >= HOLD_AFTER) begin
				held = 1'b1;
				row_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(8, 60);
			for (j = 0; j < seg; j++) begin
				case (mode)
					0:       row_stall <= 1'b0;
					1:       row_stall <= ($urandom_range(0, 3) == 0);
					2:       row_stall <= ($urandom_range(0, 3) != 0);
					default: row_stall <= j[0];
				endcase
				@(posedge clk);
			end
		end
	end

	// Take a row word at every edge where it is valid and not stalled.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && row_valid === 1'b1 && row_stall === 1'b0) begin
			sb.check_row(row);
		end
	end

endmodule
